@@ src/tcw_pkg.sv @@
// Package for the text console writer: geometry constants, command and
// operation codes, payload and queue-entry types, the tab-stop table.
// No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_ERASE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [7:0] ATTR_DEFAULT = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_DEFAULT, CHAR_NUL};

  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_PUT   = 3'd1;
  localparam logic [2:0] OP_TAB   = 3'd2;
  localparam logic [2:0] OP_LF    = 3'd3;
  localparam logic [2:0] OP_CR    = 3'd4;
  localparam logic [2:0] OP_ERASE = 3'd5;
  localparam logic [2:0] OP_READ  = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       char_code;
    logic [POS_W-1:0] cell_index;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_req_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } op_ctl_t;

  typedef logic [COL_W:0] tab_lut_t [2**COL_W];

  function automatic tab_lut_t tab_lut_build();
    tab_lut_t t;
    for (int i = 0; i < 2**COL_W; i++) begin
      t[i] = (COL_W+1)'(i + TAB_WIDTH - (i % TAB_WIDTH));
    end
    return t;
  endfunction

  localparam tab_lut_t TAB_LUT = tab_lut_build();

endpackage

`default_nettype wire

@@ src/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/tcw_front.sv @@
// Front end: classifies input requests into operations and holds them in a
// two-entry queue for the back end. Depends on tcw_pkg.
`default_nettype none

module tcw_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire tcw_pkg::in_item_t in_item,
  output tcw_pkg::op_req_t       req,
  input  wire tcw_pkg::op_ctl_t  ctl
);

  tcw_pkg::op_t q_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  tcw_pkg::op_t op_new;
  logic         push_ok;
  logic         pop_ok;

  always_comb begin
    op_new.char_code  = in_item.char_code;
    op_new.cell_index = in_item.cell_index;
    case (in_item.cmd)
      tcw_pkg::CMD_PUT: begin
        if (in_item.char_code == tcw_pkg::CHAR_TAB) begin
          op_new.kind = tcw_pkg::OP_TAB;
        end else if (in_item.char_code == tcw_pkg::CHAR_LF) begin
          op_new.kind = tcw_pkg::OP_LF;
        end else if (in_item.char_code == tcw_pkg::CHAR_CR) begin
          op_new.kind = tcw_pkg::OP_CR;
        end else begin
          op_new.kind = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::CMD_ERASE: op_new.kind = tcw_pkg::OP_ERASE;
      tcw_pkg::CMD_READ: begin
        if (in_item.cell_index < tcw_pkg::POS_W'(tcw_pkg::CELLS)) begin
          op_new.kind = tcw_pkg::OP_READ;
        end else begin
          op_new.kind = tcw_pkg::OP_NOP;
        end
      end
      default: op_new.kind = tcw_pkg::OP_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2) || ctl.init_busy;
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = ctl.pop && (cnt_r != 2'd0);
  assign req.valid = (cnt_r != 2'd0);
  assign req.op    = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push_ok ? ~wptr_r : wptr_r;
    rptr_nxt = pop_ok ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wptr_r] <= op_new;
    end
  end

endmodule

`default_nettype wire

@@ src/tcw_back.sv @@
// Back end: cursor, attribute register, screen store as a ring of rows,
// clearing sequencer and result register. Depends on tcw_pkg and tcw_ram.
`default_nettype none

module tcw_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  input  wire tcw_pkg::op_req_t  req,
  output tcw_pkg::op_ctl_t       ctl,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output tcw_pkg::out_item_t     out_item
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_SCRL = 2'd3;

  localparam int PW = tcw_pkg::POS_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam int RW = tcw_pkg::ROW_W;

  logic [1:0]    state_r, state_nxt;
  logic [7:0]    attr_r;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] rbase_r, rbase_nxt;
  logic [PW-1:0] top_r, top_nxt;
  logic [PW-1:0] clr_base_r, clr_base_nxt;
  logic [PW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  tcw_pkg::out_item_t out_r, out_nxt;

  logic                       ram_we;
  logic [PW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [PW-1:0]              ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic          out_free;
  logic          take;
  logic          do_nl;
  logic          load;
  logic          clr_last;
  logic [PW-1:0] cur_pos;
  logic [PW:0]   cur_sum;
  logic [PW-1:0] cur_phys;
  logic [PW:0]   rd_sum;
  logic [PW-1:0] rd_phys;
  logic [PW:0]   top_sum;
  logic [CW:0]   tab_col;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free      = !out_valid_r || out_pop;
  assign take          = (state_r == S_IDLE) && req.valid && out_free;
  assign ctl.pop       = take;
  assign ctl.init_busy = (state_r == S_INIT);
  assign out_empty     = !out_valid_r;
  assign out_item      = out_r;

  assign cur_pos  = rbase_r + PW'(col_r);
  assign cur_sum  = {1'b0, cur_pos} + {1'b0, top_r};
  assign cur_phys = (cur_sum >= (PW+1)'(tcw_pkg::CELLS)) ?
                    PW'(cur_sum - (PW+1)'(tcw_pkg::CELLS)) : cur_sum[PW-1:0];
  assign rd_sum   = {1'b0, req.op.cell_index} + {1'b0, top_r};
  assign rd_phys  = (rd_sum >= (PW+1)'(tcw_pkg::CELLS)) ?
                    PW'(rd_sum - (PW+1)'(tcw_pkg::CELLS)) : rd_sum[PW-1:0];
  assign top_sum  = {1'b0, top_r} + (PW+1)'(tcw_pkg::COLUMNS);
  assign tab_col  = tcw_pkg::TAB_LUT[col_r];
  assign clr_last = (state_r == S_INIT) ? (clr_cnt_r == PW'(tcw_pkg::CELLS - 1)) :
                                          (clr_cnt_r == PW'(tcw_pkg::COLUMNS - 1));

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    rbase_nxt    = rbase_r;
    top_nxt      = top_r;
    clr_base_nxt = clr_base_r;
    clr_cnt_nxt  = clr_cnt_r;
    ram_we       = 1'b0;
    ram_waddr    = cur_phys;
    ram_wdata    = {attr_r, req.op.char_code};
    ram_raddr    = rd_phys;
    do_nl        = 1'b0;
    load         = 1'b0;
    out_nxt      = out_r;

    case (state_r)
      S_INIT, S_SCRL: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_base_r + clr_cnt_r;
        ram_wdata   = tcw_pkg::BLANK_CELL;
        clr_cnt_nxt = clr_cnt_r + PW'(1);
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          load = 1'b1;
          case (req.op.kind)
            tcw_pkg::OP_PUT: begin
              ram_we = 1'b1;
              if (col_r == CW'(tcw_pkg::COLUMNS - 1)) begin
                do_nl = 1'b1;
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end
            tcw_pkg::OP_TAB: begin
              if (tab_col >= (CW+1)'(tcw_pkg::COLUMNS)) begin
                do_nl = 1'b1;
              end else begin
                col_nxt = tab_col[CW-1:0];
              end
            end
            tcw_pkg::OP_LF: do_nl = 1'b1;
            tcw_pkg::OP_CR: col_nxt = '0;
            tcw_pkg::OP_ERASE: begin
              if (col_r != '0) begin
                col_nxt   = col_r - CW'(1);
                ram_we    = 1'b1;
                ram_waddr = cur_phys - PW'(1);
                ram_wdata = {attr_r, tcw_pkg::CHAR_SPACE};
              end
            end
            tcw_pkg::OP_READ: begin
              load      = 1'b0;
              state_nxt = S_RD;
            end
            default: begin
            end
          endcase
          if (do_nl) begin
            col_nxt = '0;
            if (row_r == RW'(tcw_pkg::ROWS - 1)) begin
              top_nxt      = (top_sum >= (PW+1)'(tcw_pkg::CELLS)) ? '0 : top_sum[PW-1:0];
              clr_base_nxt = top_r;
              clr_cnt_nxt  = '0;
              state_nxt    = S_SCRL;
            end else begin
              row_nxt   = row_r + RW'(1);
              rbase_nxt = rbase_r + PW'(tcw_pkg::COLUMNS);
            end
          end
          out_nxt.cell_char  = '0;
          out_nxt.cell_attr  = '0;
          out_nxt.cursor_col = col_nxt;
          out_nxt.cursor_row = row_nxt;
          out_nxt.cursor_pos = rbase_nxt + PW'(col_nxt);
        end
      end
      S_RD: begin
        load               = 1'b1;
        state_nxt          = S_IDLE;
        out_nxt.cell_char  = ram_rdata[7:0];
        out_nxt.cell_attr  = ram_rdata[15:8];
        out_nxt.cursor_col = col_r;
        out_nxt.cursor_row = row_r;
        out_nxt.cursor_pos = cur_pos;
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = load || (out_valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      attr_r      <= tcw_pkg::ATTR_DEFAULT;
      col_r       <= '0;
      row_r       <= '0;
      rbase_r     <= '0;
      top_r       <= '0;
      clr_base_r  <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      rbase_r     <= rbase_nxt;
      top_r       <= top_nxt;
      clr_base_r  <= clr_base_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/text_console_writer_core.sv @@
// Text console writer top level: front-end classifier and queue, back-end
// executor with the screen store. Depends on tcw_pkg, tcw_front, tcw_back.
// Results are registered when the back end takes a request; a cell read
// first goes through the read state. One request per cycle while the
// result port is free and the back end idle; a bottom-row line feed scrolls
// and clears a row. After reset in_full stays high while the store clears.
`default_nettype none

module text_console_writer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire tcw_pkg::in_item_t  in_item,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output tcw_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);

  tcw_pkg::op_req_t req;
  tcw_pkg::op_ctl_t ctl;

  tcw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .req     (req),
    .ctl     (ctl)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .ctl       (ctl),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ tb/text_console_writer_core_test.sv @@
// Self-checking testbench for text_console_writer_core: drives put, erase and
// read requests with random idling and compares each result with a predicted
// console. Depends on tcw_pkg and the text_console_writer_core RTL.
`timescale 1ns / 100ps

module text_console_writer_core_test;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int HOLD_OFF_CYCLES  = 600;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 16;
  localparam int PHASE_REQUESTS   = 200;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_push   = 1'b0;
  logic               in_full;
  tcw_pkg::in_item_t  in_item   = '0;
  logic               out_empty;
  logic               out_pop   = 1'b0;
  tcw_pkg::out_item_t out_item;
  logic               cfg_we    = 1'b0;
  logic [7:0]         cfg_wdata = '0;

  logic [tcw_pkg::CELL_W-1:0] screen_image [tcw_pkg::CELLS];
  logic [tcw_pkg::COL_W-1:0]  model_col  = '0;
  logic [tcw_pkg::ROW_W-1:0]  model_row  = '0;
  logic [7:0]                 model_attr = tcw_pkg::ATTR_DEFAULT;

  tcw_pkg::out_item_t expected_reports [$];
  int  faults       = 0;
  int  quiet_cycles = 0;
  bit  push_live    = 1'b0;
  bit  send_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;
  bit  hold_off_req = 1'b0;

  text_console_writer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void advance_line();
    model_col = '0;
    if (int'(model_row) == tcw_pkg::ROWS - 1) begin
      for (int i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++) begin
        screen_image[i] = screen_image[i + tcw_pkg::COLUMNS];
      end
      for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++) begin
        screen_image[i] = tcw_pkg::BLANK_CELL;
      end
    end else begin
      model_row = model_row + tcw_pkg::ROW_W'(1);
    end
  endfunction

  function automatic tcw_pkg::out_item_t console_step(input tcw_pkg::in_item_t req);
    tcw_pkg::out_item_t rep;
    int                 next_col;
    int                 spot;
    rep = '0;
    case (req.cmd)
      tcw_pkg::CMD_PUT: begin
        case (req.char_code)
          tcw_pkg::CHAR_TAB: begin
            next_col = int'(model_col) + tcw_pkg::TAB_WIDTH -
                       (int'(model_col) % tcw_pkg::TAB_WIDTH);
            if (next_col >= tcw_pkg::COLUMNS) advance_line();
            else model_col = next_col[tcw_pkg::COL_W-1:0];
          end
          tcw_pkg::CHAR_LF: advance_line();
          tcw_pkg::CHAR_CR: model_col = '0;
          default: begin
            spot = int'(model_row) * tcw_pkg::COLUMNS + int'(model_col);
            screen_image[spot] = {model_attr, req.char_code};
            if (int'(model_col) == tcw_pkg::COLUMNS - 1) advance_line();
            else model_col = model_col + tcw_pkg::COL_W'(1);
          end
        endcase
      end
      tcw_pkg::CMD_ERASE: begin
        if (model_col != '0) begin
          model_col = model_col - tcw_pkg::COL_W'(1);
          spot = int'(model_row) * tcw_pkg::COLUMNS + int'(model_col);
          screen_image[spot] = {model_attr, tcw_pkg::CHAR_SPACE};
        end
      end
      tcw_pkg::CMD_READ: begin
        if (int'(req.cell_index) < tcw_pkg::CELLS) begin
          rep.cell_char = screen_image[req.cell_index][7:0];
          rep.cell_attr = screen_image[req.cell_index][15:8];
        end
      end
      default: ;
    endcase
    spot = int'(model_row) * tcw_pkg::COLUMNS + int'(model_col);
    rep.cursor_col = model_col;
    rep.cursor_row = model_row;
    rep.cursor_pos = spot[tcw_pkg::POS_W-1:0];
    return rep;
  endfunction

  function automatic tcw_pkg::in_item_t make_req(input logic [1:0] cmd,
                                                 input logic [7:0] ch,
                                                 input logic [10:0] idx);
    tcw_pkg::in_item_t req;
    req.cmd        = cmd;
    req.char_code  = ch;
    req.cell_index = idx;
    return req;
  endfunction

  function automatic tcw_pkg::in_item_t random_request();
    int          pick;
    int          near;
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [10:0] idx;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom);
    idx  = 11'($urandom);
    if (pick < 55) begin
      cmd = tcw_pkg::CMD_PUT;
      case ($urandom_range(0, 19))
        0, 1:    ch = tcw_pkg::CHAR_TAB;
        2, 3:    ch = tcw_pkg::CHAR_LF;
        4:       ch = tcw_pkg::CHAR_CR;
        default: ;
      endcase
    end else if (pick < 70) begin
      cmd = tcw_pkg::CMD_ERASE;
    end else if (pick < 94) begin
      cmd = tcw_pkg::CMD_READ;
      if ($urandom_range(0, 1) == 1) begin
        near = int'(model_row) * tcw_pkg::COLUMNS +
               $urandom_range(0, tcw_pkg::COLUMNS - 1);
        idx  = near[10:0];
      end
    end else begin
      cmd = CMD_UNUSED;
    end
    return make_req(cmd, ch, idx);
  endfunction

  task automatic report_fault(input string msg);
    faults++;
    if (faults <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_fault($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  task automatic park_sender();
    if (push_live) begin
      in_push  <= 1'b0;
      push_live = 1'b0;
    end
  endtask

  task automatic send_request(input tcw_pkg::in_item_t req);
    int gap;
    if (send_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      if (push_live) in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_item  <= req;
    push_live = 1'b1;
    do @(posedge clk); while (in_full);
    expected_reports.push_back(console_step(req));
  endtask

  task automatic wait_drained();
    park_sender();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_text_attr(input logic [7:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_attr = value;
  endtask

  task automatic test_directed_cases();
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00, 11'd0));
    send_request(make_req(tcw_pkg::CMD_READ, 8'hFF, 11'(tcw_pkg::CELLS - 1)));
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00, 11'h7FF));
    send_request(make_req(CMD_UNUSED, 8'hFF, 11'h7FF));
    send_request(make_req(tcw_pkg::CMD_ERASE, 8'h00, 11'd0));
    send_request(make_req(tcw_pkg::CMD_PUT, 8'hFF, 11'h7FF));
    send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_NUL, 11'd0));
    send_request(make_req(tcw_pkg::CMD_PUT, 8'h41, 11'd0));
    send_request(make_req(tcw_pkg::CMD_ERASE, 8'hFF, 11'h7FF));
    send_request(make_req(tcw_pkg::CMD_ERASE, 8'h00, 11'd0));
    send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_CR, 11'd0));
    repeat (tcw_pkg::COLUMNS / tcw_pkg::TAB_WIDTH) begin
      send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_TAB, 11'd0));
    end
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00, 11'd0));
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00, 11'd1));
    send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_LF, 11'd0));
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00, 11'(tcw_pkg::COLUMNS)));
  endtask

  task automatic test_scroll();
    set_text_attr(8'hC3);
    send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_CR, 11'd0));
    while (int'(model_row) < tcw_pkg::ROWS - 1) begin
      send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_LF, 11'd0));
    end
    send_request(make_req(tcw_pkg::CMD_PUT, 8'h53, 11'd0));
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00,
                          11'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS)));
    send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CHAR_LF, 11'd0));
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00,
                          11'((tcw_pkg::ROWS - 2) * tcw_pkg::COLUMNS)));
    send_request(make_req(tcw_pkg::CMD_READ, 8'h00,
                          11'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS)));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_text_attr(8'h00);
        1:       set_text_attr(8'hFF);
        4:       set_text_attr(tcw_pkg::ATTR_DEFAULT);
        default: set_text_attr(8'($urandom));
      endcase
      repeat (PHASE_REQUESTS) send_request(random_request());
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    send_idle_en = 1'b0;
    hold_off_req = 1'b1;
    repeat (150) send_request(random_request());
    send_idle_en = 1'b1;
  endtask

  task automatic test_quiet_tail();
    set_text_attr(8'($urandom));
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    repeat (60) send_request(random_request());
  endtask

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 16);
        out_pop <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tcw_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_reports.size() == 0) begin
        report_fault($sformatf("result with nothing pending: %p", out_item));
      end else begin
        want = expected_reports.pop_front();
        check_field("cell_char", 16'(out_item.cell_char), 16'(want.cell_char));
        check_field("cell_attr", 16'(out_item.cell_attr), 16'(want.cell_attr));
        check_field("cursor_col", 16'(out_item.cursor_col), 16'(want.cursor_col));
        check_field("cursor_row", 16'(out_item.cursor_row), 16'(want.cursor_row));
        check_field("cursor_pos", 16'(out_item.cursor_pos), 16'(want.cursor_pos));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < tcw_pkg::CELLS; i++) screen_image[i] = tcw_pkg::BLANK_CELL;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_scroll();
    test_random_traffic();
    test_backpressure();
    test_quiet_tail();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
